// File: rtl/core/mslrd_pkg.sv
// Shared constants and types of the multi-stream ranged random draw block.
package mslrd_pkg;

    // Stream bank and field widths
    localparam int STREAM_COUNT = 5;
    localparam int SEL_W        = 3;
    localparam int DATA_W       = 32;

    // Generator step: state * LCG_MUL + LCG_ADD, modulo 2^DATA_W
    localparam logic [DATA_W-1:0] LCG_MUL = 32'd10001;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd100001;

    // Restoring divider: one remainder bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Command codes
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } mslrd_state_t;

endpackage

// File: rtl/core/mslrd_if.sv
// Valid/ready channel interfaces for the command and result beats.
interface mslrd_cmd_if
    import mslrd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic                     seed_all;
    logic [SEL_W-1:0]         stream_index;
    logic [DATA_W-1:0]        seed_value;
    logic signed [DATA_W-1:0] bound_a;
    logic signed [DATA_W-1:0] bound_b;

    modport source
    (
        output valid, command, seed_all, stream_index, seed_value, bound_a, bound_b,
        input  ready
    );

    modport sink
    (
        input  valid, command, seed_all, stream_index, seed_value, bound_a, bound_b,
        output ready
    );
endinterface

interface mslrd_draw_if
    import mslrd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drawn_value;

    modport source
    (
        output valid, drawn_value,
        input  ready
    );

    modport sink
    (
        input  valid, drawn_value,
        output ready
    );
endinterface

// File: rtl/core/multi_stream_lcg_range_draw.sv
// Top level: five LCG streams with seed and ranged draw over a shared divider.
//
// Use: command beats arrive on cmd, drawn values leave on result; both are
// valid/ready channels and a beat moves when valid and ready are high together.
// A seed beat (command = seed) loads seed_value into the stream at stream_index
// (none if it is beyond the bank), or into all streams when seed_all is set; it yields no result.
// A draw beat with a valid stream_index yields one result beat; a draw naming
// a stream beyond the bank is dropped without a result.
// A draw with equal bounds goes straight to the final step and returns the first
// bound. Otherwise the generator multiply advances the stream, then the
// restoring divider (one remainder bit per cycle) forms state mod span, and the
// final step adds the lower bound. A full-range span skips the divider. cmd is
// not ready while a draw is in progress and is ready again once the result is
// registered; seeds may follow every cycle.
// The output register holds one finished value: the next command is taken while
// it waits, but a further draw holds in its final step until result is free.
// Reset clears all stream states to zero and empties the output register.
module multi_stream_lcg_range_draw
    import mslrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mslrd_cmd_if.sink    cmd,
    mslrd_draw_if.source result
);

    mslrd_state_t      state_reg, state_next;
    logic [DATA_W-1:0] stream_reg [STREAM_COUNT];
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] span_reg, span_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;

    logic              idx_ok;
    logic              swap;
    logic              wr_all;
    logic              wr_one;
    logic [SEL_W-1:0]  wr_sel;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] span_calc;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    assign idx_ok = ({1'b0, cmd.stream_index} < (SEL_W+1)'(STREAM_COUNT));
    assign swap   = (cmd.bound_b < cmd.bound_a);

    // Generator step and span share the multiply cycle
    assign prod      = stream_reg[sel_reg] * LCG_MUL + LCG_ADD;
    assign span_calc = hi_reg - lo_reg + DATA_W'(1);

    // One restoring divider step
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, span_reg};

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        cmd.ready      = 1'b0;
        wr_all         = 1'b0;
        wr_one         = 1'b0;
        wr_sel         = cmd.stream_index;
        wr_data        = cmd.seed_value;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    sel_next = cmd.stream_index;
                    case (cmd.command)
                        CMD_SEED:
                        begin
                            wr_all = cmd.seed_all;
                            wr_one = !cmd.seed_all && idx_ok;
                        end
                        CMD_DRAW:
                        begin
                            if (idx_ok)
                            begin
                                if (cmd.bound_a == cmd.bound_b)
                                begin
                                    // Equal bounds: return the first bound unchanged
                                    rem_next   = cmd.bound_a;
                                    lo_next    = '0;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    lo_next    = swap ? cmd.bound_b : cmd.bound_a;
                                    hi_next    = swap ? cmd.bound_a : cmd.bound_b;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                // Advance the stream and set up the divider
                wr_one    = 1'b1;
                wr_sel    = sel_reg;
                wr_data   = prod;
                span_next = span_calc;
                quo_next  = prod;
                cnt_next  = '0;
                if (span_calc == '0)
                begin
                    // Full range: span wraps to zero, take the state as is
                    rem_next   = prod;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rem_reg + lo_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stream bank: cleared at reset, seeded one entry or all at once, advanced one entry at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STREAM_COUNT; k++)
            begin
                stream_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < STREAM_COUNT; k++)
            begin
                if (wr_all || (wr_one && wr_sel == SEL_W'(k)))
                begin
                    stream_reg[k] <= wr_data;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        span_reg      <= span_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.drawn_value = out_value_reg;

    // Remainder stays below the divisor throughout the division
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < span_reg)
    else $error("divider remainder reached the span");

    // A result only appears at the end of the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    else $error("result raised outside the final step");

    // The selected stream does not move while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |=> $stable(stream_reg[sel_reg]))
    else $error("stream changed during division");

    // Division ends after the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> state_reg == ST_DONE)
    else $error("divider overran its step count");

endmodule

// File: tb/mslrd_draw_predict.sv
`timescale 1ns / 1ps
// Predictor and result comparison for the multi-stream ranged draw testbench.
module mslrd_draw_predict
    import mslrd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mslrd_cmd_if   cmd,
    mslrd_draw_if  result,
    output int     fail_count,
    output int     pending_draws
);

    localparam int REPORT_LIMIT = 10;

    logic [DATA_W-1:0]        lcg_state [STREAM_COUNT];
    logic signed [DATA_W-1:0] expected_draws [$];

    // Map an advanced state into [lo, hi]; a span that wraps to zero adds lo only
    function automatic logic [DATA_W-1:0] fold_into_range(input logic [DATA_W-1:0] state,
                                                           input logic [DATA_W-1:0] lo,
                                                           input logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] span;
        span = hi - lo + 1'b1;
        if (span == '0)
            return state + lo;
        return (state % span) + lo;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [DATA_W-1:0]        lo;
        logic [DATA_W-1:0]        hi;
        logic [DATA_W-1:0]        advanced;
        logic signed [DATA_W-1:0] wanted;
        if (!rst_n)
        begin
            foreach (lcg_state[k])
                lcg_state[k] = '0;
            expected_draws.delete();
            fail_count = 0;
        end
        else
        begin
            // Match the result beat against the oldest pending draw
            if (result.valid && result.ready)
            begin
                if (expected_draws.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result beat %0d (0x%08h) with no draw pending",
                                 $realtime, result.drawn_value, result.drawn_value);
                end
                else
                begin
                    wanted = expected_draws.pop_front();
                    if (result.drawn_value !== wanted)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: drawn_value expected %0d (0x%08h), got %0d (0x%08h)",
                                     $realtime, wanted, wanted,
                                     result.drawn_value, result.drawn_value);
                    end
                end
            end

            // Follow the beat: seeds load; valid draws queue, unequal ones advance
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.command == CMD_SEED)
                begin
                    if (cmd.seed_all)
                    begin
                        foreach (lcg_state[k])
                            lcg_state[k] = cmd.seed_value;
                    end
                    else if (cmd.stream_index < STREAM_COUNT)
                        lcg_state[cmd.stream_index] = cmd.seed_value;
                end
                else if (cmd.stream_index < STREAM_COUNT)
                begin
                    if (cmd.bound_a == cmd.bound_b)
                        expected_draws.push_back(cmd.bound_a);
                    else
                    begin
                        // Order the bounds as signed values
                        if (cmd.bound_b < cmd.bound_a)
                        begin
                            lo = cmd.bound_b;
                            hi = cmd.bound_a;
                        end
                        else
                        begin
                            lo = cmd.bound_a;
                            hi = cmd.bound_b;
                        end
                        advanced = lcg_state[cmd.stream_index] * LCG_MUL + LCG_ADD;
                        lcg_state[cmd.stream_index] = advanced;
                        expected_draws.push_back(fold_into_range(advanced, lo, hi));
                    end
                end
            end
        end
        pending_draws = expected_draws.size();
    end

endmodule

// File: tb/multi_stream_lcg_range_draw_tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, seed and draw stimulus, result back-pressure and verdict.
module multi_stream_lcg_range_draw_tb;
    import mslrd_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int MODE_STRIDE  = 150;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_draws;
    bit   send_idle_on;
    bit   take_idle_on;
    int   take_hold_req;
    int   taken_items;

    mslrd_cmd_if  cmd ();
    mslrd_draw_if result ();

    multi_stream_lcg_range_draw uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .result (result)
    );

    mslrd_draw_predict draw_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .result        (result),
        .fail_count    (fail_count),
        .pending_draws (pending_draws)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one command beat, after a random gap when idling is on, and hold it until taken
    task automatic send_cmd(input logic command, input logic seed_all,
                            input logic [SEL_W-1:0] idx, input logic [DATA_W-1:0] seed,
                            input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd.valid        <= 1'b1;
        cmd.command      <= command;
        cmd.seed_all     <= seed_all;
        cmd.stream_index <= idx;
        cmd.seed_value   <= seed;
        cmd.bound_a      <= a;
        cmd.bound_b      <= b;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (idx < STREAM_COUNT || (command == CMD_SEED && seed_all))
            taken_items++;
    endtask

    // Draw beat; the seed fields carry noise
    task automatic draw(input logic [SEL_W-1:0] idx, input logic [DATA_W-1:0] a,
                        input logic [DATA_W-1:0] b);
        send_cmd(CMD_DRAW, 1'($urandom), idx, $urandom, a, b);
    endtask

    // Seed beat; the bound fields carry noise
    task automatic seed(input logic seed_all, input logic [SEL_W-1:0] idx,
                        input logic [DATA_W-1:0] value);
        send_cmd(CMD_SEED, seed_all, idx, value, $urandom, $urandom);
    endtask

    // Let every pending draw come out before going on
    task automatic drain_draws();
        @(negedge clk);
        cmd.valid <= 1'b0;
        wait (pending_draws == 0);
    endtask

    // Pick a bound pair: equal, narrow, near zero, extremes, wide or arbitrary
    function automatic void pick_bounds(output logic [DATA_W-1:0] a,
                                        output logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] edges [4];
        logic [DATA_W-1:0] t;
        edges = '{MOST_NEG, MOST_POS, '0, '1};
        case ($urandom_range(0, 9))
            0:
            begin
                a = $urandom;
                b = a;
            end
            1, 2:
            begin
                a = $urandom;
                b = a + $urandom_range(1, 16);
            end
            3:
            begin
                a = $urandom_range(0, 200) - 100;
                b = $urandom_range(0, 200) - 100;
            end
            4:
            begin
                a = edges[$urandom_range(0, 3)];
                b = edges[$urandom_range(0, 3)];
            end
            5:
            begin
                a = $urandom;
                b = a ^ MOST_NEG;
            end
            default:
            begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    // Result side: random stalls, a long hold on request, always ready otherwise
    initial
    begin : take_results
        int stall;
        result.ready = 1'b0;
        forever
        begin
            if (take_hold_req > 0)
            begin
                stall = take_hold_req;
                take_hold_req = 0;
            end
            else
                stall = take_idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                result.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result.valid && rst_n));
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int                pick;
        int                iter;
        rst_n            = 1'b0;
        cmd.valid        = 1'b0;
        cmd.command      = CMD_SEED;
        cmd.seed_all     = 1'b0;
        cmd.stream_index = '0;
        cmd.seed_value   = '0;
        cmd.bound_a      = '0;
        cmd.bound_b      = '0;
        send_idle_on     = 1'b1;
        take_idle_on     = 1'b1;
        take_hold_req    = 0;
        taken_items      = 0;
        iter             = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: equal bounds, extremes, reversed order, full range, wrap, bad stream
        draw(0, 32'd0, 32'd0);
        draw(0, 32'd0, 32'd9);
        draw(1, MOST_POS, MOST_POS);
        draw(2, MOST_NEG, MOST_NEG);
        draw(3, MOST_NEG, MOST_POS);
        draw(4, MOST_POS, MOST_NEG);
        draw(0, 32'd100, -32'sd100);
        draw(1, MOST_NEG, 32'd0);
        draw(2, 32'h7FFF_FFF0, MOST_POS);
        draw(5, 32'd1, 32'd2);
        draw(7, 32'd5, 32'd5);
        seed(1'b1, 7, 32'hFFFF_FFFF);
        draw(4, -32'sd1, 32'd0);
        seed(1'b0, 6, 32'd1234);
        seed(1'b0, 3, 32'd0);
        draw(3, 32'd0, 32'd1000);
        draw(2, -32'sd5, 32'd5);
        seed(1'b0, 0, MOST_NEG);
        draw(0, -32'sd2, -32'sd1);
        draw(0, MOST_NEG, MOST_POS);
        draw(1, 32'd1, -32'sd1);
        seed(1'b1, 0, 32'd0);
        draw(6, MOST_NEG, MOST_POS);
        drain_draws();

        // Random: mostly draws on live streams between occasional reseeds
        taken_items = 0;
        while (taken_items < ITEM_TARGET)
        begin
            // Change the idle pattern now and then, sometimes dropping it
            if (iter % MODE_STRIDE == 0)
            begin
                send_idle_on = $urandom_range(0, 3) != 0;
                take_idle_on = $urandom_range(0, 3) != 0;
            end
            // Hold off results for a long stretch while commands keep coming
            if (iter == 300)
                take_hold_req = LONG_HOLD;
            // Pause commands until every draw has come out
            if (iter == 700)
                drain_draws();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                seed(1'($urandom), SEL_W'($urandom_range(0, 7)), $urandom);
            else
            begin
                pick_bounds(a, b);
                if (pick < 14)
                    draw(SEL_W'($urandom_range(STREAM_COUNT, 7)), a, b);
                else
                    draw(SEL_W'($urandom_range(0, STREAM_COUNT - 1)), a, b);
            end
            iter++;
        end

        drain_draws();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_draws == 0)
            $display("multi_stream_lcg_range_draw_tb: done, clean");
        else
            $display("multi_stream_lcg_range_draw_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("multi_stream_lcg_range_draw_tb: done, errors");
        $finish;
    end

endmodule
